### rtl/core/nrcw_pkg.sv
// nrcw_pkg: shared types, codes, register reset values and helpers of the
// newreno congestion window engine; no dependencies

package nrcw_pkg;

	localparam int BYTE_W  = 32;
	localparam int TIME_W  = 48;
	localparam int REG_W   = 16;
	localparam int NUM_W   = BYTE_W + REG_W;
	localparam int CFG_IDX_W = 3;
	localparam int STEP_W  = $clog2(NUM_W + 1);

	// event codes
	typedef enum logic [2:0] {
		OP_START     = 3'd0,
		OP_SENT      = 3'd1,
		OP_REMOVE    = 3'd2,
		OP_ACK_BEGIN = 3'd3,
		OP_ACKED     = 3'd4,
		OP_LOSS      = 3'd5
	} op_t;

	// fault codes
	localparam logic [1:0] FAULT_NONE      = 2'd0;
	localparam logic [1:0] FAULT_UNDERFLOW = 2'd1;
	localparam logic [1:0] FAULT_OVERFLOW  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PACKET_LEN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WINDOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_WINDOW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AVOID_LEN   = 3'd4;

	// register reset values
	localparam logic [REG_W-1:0] RST_PACKET_LEN  = 16'd1252;
	localparam logic [REG_W-1:0] RST_MIN_WINDOW  = 16'd2;
	localparam logic [REG_W-1:0] RST_MAX_WINDOW  = 16'd2000;
	localparam logic [REG_W-1:0] RST_INIT_WINDOW = 16'd10;
	localparam logic [REG_W-1:0] RST_AVOID_LEN   = 16'd1252;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_MUL_X,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_APPLY,
		ST_BOUND,
		ST_FINISH
	} state_t;

	// divider request and response
	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [BYTE_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [NUM_W-1:0]  quot;
	} div_rsp_t;

	// clip to the upper limit, then raise to the lower one (the lower wins)
	function automatic logic [BYTE_W-1:0] bound_window(
		input logic [BYTE_W-1:0] w,
		input logic [BYTE_W-1:0] hi,
		input logic [BYTE_W-1:0] lo
	);
		logic [BYTE_W-1:0] r;
		r = (w > hi) ? hi : w;
		if (r < lo) r = lo;
		return r;
	endfunction

	localparam logic [BYTE_W-1:0] RST_WINDOW = bound_window(
		BYTE_W'(RST_INIT_WINDOW) * BYTE_W'(RST_PACKET_LEN),
		BYTE_W'(RST_MAX_WINDOW) * BYTE_W'(RST_PACKET_LEN),
		BYTE_W'(RST_MIN_WINDOW) * BYTE_W'(RST_PACKET_LEN));

endpackage

### rtl/core/newreno_congestion_window.sv
// newreno_congestion_window: per-connection newreno window engine, top level
// depends on nrcw_pkg and nrcw_divider
//
// usage
//  - config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the five
//    16-bit registers; cfg_ready is always high, indexes past the list are dropped
//  - input channel (in_valid/in_stall) carries one event per transaction; a
//    transaction completes when in_valid is high and in_stall is low
//  - output channel (out_valid/out_stall) returns exactly one result per event
//    with the state after that event
//  - one event at a time: a small sequencer drives a single 32x16 multiplier
//    (window limits, initial window, avoidance numerator) and then a radix-2
//    divider for congestion-avoidance growth
//  - an input transaction passes through the limit products, the event product,
//    an optional division for congestion-avoidance growth, apply, bound and
//    finish before out_valid; in_stall drops in the same cycle out_valid rises
//  - a new event is taken only after the previous one has left the sequencer
//  - a result waiting on out_stall does not block the next event, which runs
//    until its own result is ready and then holds until the output is free
//  - reset clears the registers to their defaults and the state to the start
//    values: window 12520, threshold all ones, flight and recovery zero

module newreno_congestion_window import nrcw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	// events
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           opcode,
	input  logic [31:0]          byte_count,
	input  logic [TIME_W-1:0]    sent_time,
	input  logic [TIME_W-1:0]    now_time,
	input  logic                 last_of_ack,
	input  logic                 persistent,
	// results
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [31:0]          window_bytes,
	output logic [31:0]          threshold_bytes,
	output logic [31:0]          flight_bytes,
	output logic [31:0]          writable_bytes,
	output logic                 slow_start,
	output logic [1:0]           fault
);

	localparam logic [BYTE_W-1:0] BYTE_MAX = '1;

	// configuration registers
	logic [REG_W-1:0] packet_len_q, min_pkts_q, max_pkts_q, init_pkts_q, avoid_len_q;

	// connection state
	logic [BYTE_W-1:0] window_q, thr_q, flight_q;
	logic [TIME_W-1:0] rec_end_q;
	logic              rec_valid_q;

	// captured event
	logic [2:0]        op_q;
	logic [BYTE_W-1:0] bytes_q;
	logic [TIME_W-1:0] sent_q, now_q;
	logic              last_q, pers_q;

	// sequencer working registers
	logic [BYTE_W-1:0] hi_q, lo_q;
	logic [NUM_W-1:0]  prod_q;
	logic [1:0]        fault_q;
	logic              bound_q, copy_q;

	// output registers
	logic              out_valid_q;
	logic [BYTE_W-1:0] win_out_q, thr_out_q, flt_out_q, wr_out_q;
	logic              ss_out_q;
	logic [1:0]        fault_out_q;

	state_t state_q, state_d;

	// sequencer controls
	logic in_take, out_load, div_start;

	// shared multiplier
	logic [BYTE_W-1:0] mul_a;
	logic [REG_W-1:0]  mul_b;
	logic [NUM_W-1:0]  mul_p;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic grow, in_ss, new_loss, need_div;
	logic [BYTE_W:0]   add_bytes;
	logic [NUM_W:0]    add_quot;
	logic [BYTE_W-1:0] win_bounded;
	logic [BYTE_W-1:0] sub_flight;
	logic              sub_under;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_len_q <= RST_PACKET_LEN;
			min_pkts_q   <= RST_MIN_WINDOW;
			max_pkts_q   <= RST_MAX_WINDOW;
			init_pkts_q  <= RST_INIT_WINDOW;
			avoid_len_q  <= RST_AVOID_LEN;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PACKET_LEN:  packet_len_q <= cfg_data;
				REG_MIN_WINDOW:  min_pkts_q   <= cfg_data;
				REG_MAX_WINDOW:  max_pkts_q   <= cfg_data;
				REG_INIT_WINDOW: init_pkts_q  <= cfg_data;
				REG_AVOID_LEN:   avoid_len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// event decode on the captured transaction
	assign grow     = !(rec_valid_q && (sent_q < rec_end_q));
	assign in_ss    = window_q < thr_q;
	assign new_loss = !rec_valid_q || (rec_end_q < sent_q);
	assign need_div = (op_q == OP_ACKED) && grow && !in_ss;

	// multiplier operand selection: limits first, then the per-event product
	always_comb begin
		mul_a = BYTE_W'(max_pkts_q);
		mul_b = packet_len_q;
		case (state_q)
			ST_MUL_LO: begin
				mul_a = BYTE_W'(min_pkts_q);
			end
			ST_MUL_X: begin
				if (op_q == OP_START) begin
					mul_a = BYTE_W'(init_pkts_q);
				end else begin
					mul_a = bytes_q;
					mul_b = avoid_len_q;
				end
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// avoidance growth divides by the window, a zero window counts as one
	assign div_req.start = div_start;
	assign div_req.num   = prod_q;
	assign div_req.den   = (window_q != '0) ? window_q : BYTE_W'(1);

	nrcw_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_MUL_HI;
			ST_MUL_HI:   state_d = ST_MUL_LO;
			ST_MUL_LO:   state_d = ST_MUL_X;
			ST_MUL_X:    state_d = need_div ? ST_DIV_GO : ST_APPLY;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_rsp.done) state_d = ST_APPLY;
			ST_APPLY:    state_d = ST_BOUND;
			ST_BOUND:    state_d = ST_FINISH;
			ST_FINISH:   if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		in_take   = 1'b0;
		out_load  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				in_take  = in_valid;
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
			end
			ST_FINISH: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// saturating and clamping arithmetic for the apply step
	assign add_bytes  = {1'b0, flight_q} + {1'b0, bytes_q};
	assign sub_under  = bytes_q > flight_q;
	assign sub_flight = sub_under ? '0 : flight_q - bytes_q;
	assign add_quot   = (NUM_W + 1)'(window_q) + {1'b0, div_rsp.quot};
	assign win_bounded = bound_q ? bound_window(window_q, hi_q, lo_q) : window_q;

	logic [BYTE_W:0] win_plus_bytes;
	assign win_plus_bytes = {1'b0, window_q} + {1'b0, bytes_q};

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q    <= opcode;
			bytes_q <= byte_count;
			sent_q  <= sent_time;
			now_q   <= now_time;
			last_q  <= last_of_ack;
			pers_q  <= persistent;
		end
		case (state_q)
			ST_MUL_HI: hi_q   <= mul_p[BYTE_W-1:0];
			ST_MUL_LO: lo_q   <= mul_p[BYTE_W-1:0];
			ST_MUL_X:  prod_q <= mul_p;
			default: ;
		endcase
	end

	// connection state and per-event flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= RST_WINDOW;
			thr_q       <= BYTE_MAX;
			flight_q    <= '0;
			rec_end_q   <= '0;
			rec_valid_q <= 1'b0;
			fault_q     <= FAULT_NONE;
			bound_q     <= 1'b0;
			copy_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_APPLY: begin
					fault_q <= FAULT_NONE;
					bound_q <= 1'b0;
					copy_q  <= 1'b0;
					case (op_q)
						OP_START: begin
							window_q    <= prod_q[BYTE_W-1:0];
							thr_q       <= BYTE_MAX;
							flight_q    <= '0;
							rec_end_q   <= '0;
							rec_valid_q <= 1'b0;
							bound_q     <= 1'b1;
						end
						OP_SENT: begin
							if (add_bytes[BYTE_W]) begin
								flight_q <= BYTE_MAX;
								fault_q  <= FAULT_OVERFLOW;
							end else begin
								flight_q <= add_bytes[BYTE_W-1:0];
							end
						end
						OP_REMOVE, OP_ACK_BEGIN: begin
							flight_q <= sub_flight;
							if (sub_under) fault_q <= FAULT_UNDERFLOW;
						end
						OP_ACKED: begin
							bound_q <= last_q;
							if (grow) begin
								if (in_ss) begin
									if (win_plus_bytes[BYTE_W]) begin
										window_q <= BYTE_MAX;
										fault_q  <= FAULT_OVERFLOW;
									end else begin
										window_q <= win_plus_bytes[BYTE_W-1:0];
									end
								end else begin
									if (add_quot[NUM_W:BYTE_W] != '0) begin
										window_q <= BYTE_MAX;
										fault_q  <= FAULT_OVERFLOW;
									end else begin
										window_q <= add_quot[BYTE_W-1:0];
									end
								end
							end
						end
						OP_LOSS: begin
							flight_q <= sub_flight;
							if (sub_under) fault_q <= FAULT_UNDERFLOW;
							// a loss past the recovery point opens a new recovery
							if (new_loss) begin
								rec_end_q   <= now_q;
								rec_valid_q <= 1'b1;
								window_q    <= window_q >> 1;
								bound_q     <= 1'b1;
								copy_q      <= 1'b1;
							end
						end
						default: ;
					endcase
				end
				ST_BOUND: begin
					if (copy_q) thr_q <= win_bounded;
					// persistent congestion collapses to the minimum window
					if ((op_q == OP_LOSS) && pers_q) begin
						window_q <= lo_q;
					end else begin
						window_q <= win_bounded;
					end
				end
				default: ;
			endcase
		end
	end

	// output register, loaded once the previous result has left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			win_out_q   <= window_q;
			thr_out_q   <= thr_q;
			flt_out_q   <= flight_q;
			wr_out_q    <= (flight_q > window_q) ? '0 : window_q - flight_q;
			ss_out_q    <= window_q < thr_q;
			fault_out_q <= fault_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign window_bytes    = win_out_q;
	assign threshold_bytes = thr_out_q;
	assign flight_bytes    = flt_out_q;
	assign writable_bytes  = wr_out_q;
	assign slow_start      = ss_out_q;
	assign fault           = fault_out_q;

endmodule

### rtl/core/nrcw_divider.sv
// nrcw_divider: radix-2 restoring divider, one quotient bit per cycle
// depends on nrcw_pkg

module nrcw_divider import nrcw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [NUM_W-1:0]  num_q;
	logic [BYTE_W-1:0] den_q;
	logic [BYTE_W-1:0] rem_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [BYTE_W:0] rem_sh;
	logic [BYTE_W:0] rem_sub;
	logic            ge;

	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[BYTE_W-1:0] : rem_sh[BYTE_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;

endmodule
